### design/utcld_pkg.sv
package utcld_pkg;

   localparam int YearWidth   = 12;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;

   localparam int ZoneHoursWidth = 4;
   localparam int CsrIndexWidth  = 1;
   localparam int CsrDataWidth   = 4;

   localparam logic [ZoneHoursWidth-1:0] MaxZoneHours = 4'd12;
   localparam logic [HourWidth:0]        HoursPerDay  = 6'd24;

   localparam logic [MonthWidth-1:0] January  = 4'd1;
   localparam logic [MonthWidth-1:0] February = 4'd2;
   localparam logic [MonthWidth-1:0] April    = 4'd4;
   localparam logic [MonthWidth-1:0] June     = 4'd6;
   localparam logic [MonthWidth-1:0] September = 4'd9;
   localparam logic [MonthWidth-1:0] November = 4'd11;
   localparam logic [MonthWidth-1:0] December = 4'd12;

   localparam logic [DayWidth-1:0] FirstDay = 5'd1;
   localparam logic [DayWidth-1:0] LastDayLong = 5'd31;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ZONE_HOURS = 1'b0,
      CSR_ZONE_EAST  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [YearWidth-1:0]   utc_year;
      logic [MonthWidth-1:0]  utc_month;
      logic [DayWidth-1:0]    utc_day;
      logic [HourWidth-1:0]   utc_hour;
      logic [MinuteWidth-1:0] utc_minute;
      logic [SecondWidth-1:0] utc_second;
   } req_type;

   typedef struct packed {
      logic [YearWidth-1:0]   local_year;
      logic [MonthWidth-1:0]  local_month;
      logic [DayWidth-1:0]    local_day;
      logic [HourWidth-1:0]   local_hour;
      logic [MinuteWidth-1:0] local_minute;
      logic [SecondWidth-1:0] local_second;
   } rsp_type;

   // year / 4 is a multiple of 25: compare against every multiple in range
   function automatic logic is_century(input logic [YearWidth-1:0] y);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k * 25 < (1 << (YearWidth - 2)); k++) begin
         if (y[YearWidth-1:2] == (YearWidth-2)'(k * 25)) begin
            hit = 1'b1;
         end
      end
      return hit && (y[1:0] == 2'b00);
   endfunction

   // year / 16 is a multiple of 25
   function automatic logic is_quad_century(input logic [YearWidth-1:0] y);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k * 25 < (1 << (YearWidth - 4)); k++) begin
         if (y[YearWidth-1:4] == (YearWidth-4)'(k * 25)) begin
            hit = 1'b1;
         end
      end
      return hit && (y[3:0] == 4'b0000);
   endfunction

   function automatic logic is_leap(input logic [YearWidth-1:0] y);
      return (y[1:0] == 2'b00) && (is_quad_century(y) || !is_century(y));
   endfunction

   function automatic logic [DayWidth-1:0] month_days(
      input logic [MonthWidth-1:0] m,
      input logic                  leap
   );
      logic [DayWidth-1:0] days;
      case (m)
         April, June, September, November: days = 5'd30;
         February: days = leap ? 5'd29 : 5'd28;
         default:  days = LastDayLong;
      endcase
      return days;
   endfunction

endpackage

### design/utc_to_local_date_time_core.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_data  (utcld_pkg::req_type)
// rsp_      out        rsp_valid/rsp_stall   rsp_data  (utcld_pkg::rsp_type)
// csr_      in         csr_write             csr_index, csr_data
//
// One transaction per cycle while req_stall is low.
// Input register feeds one pass of calendar logic into the result register.
// req_stall rises only when both registers hold a transaction and rsp_stall is high.
// Synchronous reset empties both registers, zone_hours to 0 and zone_east to 1.
module utc_to_local_date_time_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  utcld_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output utcld_pkg::rsp_type                 rsp_data,
   input  logic                               csr_write,
   input  logic [utcld_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [utcld_pkg::CsrDataWidth-1:0]  csr_data
);
   import utcld_pkg::*;

   logic [ZoneHoursWidth-1:0] zone_hours_ff;
   logic                      zone_east_ff;

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_hours_ff <= '0;
         zone_east_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_ZONE_HOURS: zone_hours_ff <= csr_data[ZoneHoursWidth-1:0];
            CSR_ZONE_EAST:  zone_east_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [YearWidth-1:0]  yy;
      logic [MonthWidth-1:0] mo;
      logic [DayWidth-1:0]   dd;
      logic [HourWidth:0]    sum;
      logic [HourWidth:0]    hh_wide;
      logic [HourWidth:0]    g_wide;
      logic                  month_ok;
      logic                  leap;
      logic [MonthWidth-1:0] mo_prev;

      yy       = req_ff.utc_year;
      mo       = req_ff.utc_month;
      dd       = req_ff.utc_day;
      hh_wide  = {1'b0, req_ff.utc_hour};
      g_wide   = (HourWidth+1)'(zone_hours_ff);
      sum      = hh_wide + g_wide;
      month_ok = (mo >= January) && (mo <= December);
      leap     = is_leap(yy);
      mo_prev  = mo - 4'd1;

      rsp_in.local_hour   = req_ff.utc_hour;
      rsp_in.local_minute = req_ff.utc_minute;
      rsp_in.local_second = req_ff.utc_second;

      if (zone_hours_ff != '0 && zone_hours_ff <= MaxZoneHours) begin
         if (zone_east_ff) begin
            if (sum < HoursPerDay) begin
               rsp_in.local_hour = sum[HourWidth-1:0];
            end else begin
               rsp_in.local_hour = HourWidth'(sum - HoursPerDay);
               if (month_ok) begin
                  if (dd < month_days(mo, leap)) begin
                     dd = dd + 5'd1;
                  end else begin
                     dd = FirstDay;
                     if (mo == December) begin
                        mo = January;
                        yy = yy + 12'd1;
                     end else begin
                        mo = mo + 4'd1;
                     end
                  end
               end
            end
         end else begin
            if (hh_wide >= g_wide) begin
               rsp_in.local_hour = HourWidth'(hh_wide - g_wide);
            end else begin
               rsp_in.local_hour = HourWidth'(hh_wide + HoursPerDay - g_wide);
               if (month_ok) begin
                  if (dd > FirstDay) begin
                     dd = dd - 5'd1;
                  end else if (mo == January) begin
                     mo = December;
                     dd = LastDayLong;
                     yy = yy - 12'd1;
                  end else begin
                     mo = mo_prev;
                     dd = month_days(mo_prev, leap);
                  end
               end
            end
         end
      end

      rsp_in.local_year  = yy;
      rsp_in.local_month = mo;
      rsp_in.local_day   = dd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (rsp_free && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### design/utcld_checker.sv
module utcld_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input utcld_pkg::req_type                  req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input utcld_pkg::rsp_type                  rsp_data,
   input logic                                csr_write,
   input logic [utcld_pkg::CsrIndexWidth-1:0] csr_index,
   input logic [utcld_pkg::CsrDataWidth-1:0]  csr_data
);
   import utcld_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_data, csr_write, csr_index, csr_data};

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side can move");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register is empty");

endmodule

bind utc_to_local_date_time_core utcld_checker u_utcld_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_write (csr_write),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

### sim/utc_local_checker.sv
module utc_local_checker
   import utcld_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output int                       mismatches,
   output int                       outstanding
);

   rsp_type                   local_times_due[$];
   logic [ZoneHoursWidth-1:0] zone_hours_now = '0;
   logic                      zone_east_now  = 1'b1;
   int                        error_total    = 0;

   function automatic bit is_leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(input int m, input int y);
      int days;
      case (MonthWidth'(m))
         April, June, September, November: days = 30;
         February: days = is_leap_year(y) ? 29 : 28;
         default:  days = 31;
      endcase
      return days;
   endfunction

   function automatic rsp_type to_local_time(
      input req_type                   utc,
      input logic [ZoneHoursWidth-1:0] shift_hours,
      input logic                      east
   );
      int      yr, mon, dy, hr, sh;
      bit      month_ok;
      rsp_type r;
      yr = utc.utc_year;
      mon = utc.utc_month;
      dy = utc.utc_day;
      hr = utc.utc_hour;
      sh = shift_hours;
      month_ok = (mon >= January) && (mon <= December);
      if (sh != 0 && sh <= MaxZoneHours) begin
         if (east) begin
            if (hr + sh < 24) begin
               hr = hr + sh;
            end else begin
               hr = hr + sh - 24;
               if (month_ok) begin
                  if (dy < days_in_month(mon, yr)) begin
                     dy++;
                  end else begin
                     dy = 1;
                     if (mon == December) begin
                        mon = January;
                        yr = (yr + 1) % 4096;
                     end else begin
                        mon++;
                     end
                  end
               end
            end
         end else begin
            if (hr >= sh) begin
               hr = hr - sh;
            end else begin
               hr = hr + 24 - sh;
               if (month_ok) begin
                  if (dy > 1) begin
                     dy--;
                  end else if (mon == January) begin
                     mon = December;
                     dy = 31;
                     yr = (yr + 4095) % 4096;
                  end else begin
                     mon--;
                     dy = days_in_month(mon, yr);
                  end
               end
            end
         end
      end
      r.local_year   = YearWidth'(yr);
      r.local_month  = MonthWidth'(mon);
      r.local_day    = DayWidth'(dy);
      r.local_hour   = HourWidth'(hr);
      r.local_minute = utc.utc_minute;
      r.local_second = utc.utc_second;
      return r;
   endfunction

   function automatic void split_fields(input rsp_type r, output logic [31:0] v[6]);
      v[0] = r.local_year;
      v[1] = r.local_month;
      v[2] = r.local_day;
      v[3] = r.local_hour;
      v[4] = r.local_minute;
      v[5] = r.local_second;
   endfunction

   always @(posedge clock) begin
      rsp_type     want;
      logic [31:0] want_f[6];
      logic [31:0] got_f[6];
      string       field_names[6];
      field_names = '{"year", "month", "day", "hour", "minute", "second"};
      if (reset) begin
         local_times_due.delete();
         zone_hours_now = '0;
         zone_east_now  = 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (local_times_due.size() == 0) begin
               $display("%0t: unexpected transaction, actual %p", $time, rsp_data);
               error_total++;
            end else begin
               want = local_times_due.pop_front();
               split_fields(want, want_f);
               split_fields(rsp_data, got_f);
               for (int i = 0; i < 6; i++) begin
                  if (got_f[i] !== want_f[i]) begin
                     $display("%0t: local %s mismatch, expected %0d, actual %0d",
                              $time, field_names[i], want_f[i], got_f[i]);
                     error_total++;
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            local_times_due.push_back(to_local_time(req_data, zone_hours_now, zone_east_now));
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ZONE_HOURS: zone_hours_now = csr_data[ZoneHoursWidth-1:0];
               CSR_ZONE_EAST:  zone_east_now  = csr_data[0];
               default: ;
            endcase
         end
      end
      outstanding <= local_times_due.size();
      mismatches  <= error_total;
   end

endmodule

### sim/tb_utc_to_local_date_time_core.sv
module tb_utc_to_local_date_time_core;
   import utcld_pkg::*;

   localparam int QuietLimit = 2000;
   localparam int HoldCycles = 80;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   int mismatches;
   int outstanding;
   int quiet_cycles = 0;
   int holds_asked  = 0;
   int holds_done   = 0;
   int hold_left    = 0;
   int pattern_left = 0;
   int stall_pct    = 0;

   utc_to_local_date_time_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   utc_local_checker calendar_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall patterns, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_done + 1;
         hold_left = HoldCycles;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end else begin
            pattern_left = pattern_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic req_type stamp(input int y, input int mo, input int d,
                                     input int h, input int mi, input int s);
      req_type t;
      t.utc_year   = YearWidth'(y);
      t.utc_month  = MonthWidth'(mo);
      t.utc_day    = DayWidth'(d);
      t.utc_hour   = HourWidth'(h);
      t.utc_minute = MinuteWidth'(mi);
      t.utc_second = SecondWidth'(s);
      return t;
   endfunction

   function automatic req_type random_stamp();
      logic [63:0] raw;
      int          y, d, h;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 12) begin
         return raw[$bits(req_type)-1:0];
      end
      case ($urandom_range(0, 5))
         0: y = 0;
         1: y = 4095;
         2: y = 100 * $urandom_range(0, 40);
         3: y = 4 * $urandom_range(0, 1023);
         default: y = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 3))
         0: d = 1;
         1: d = $urandom_range(28, 31);
         default: d = $urandom_range(1, 31);
      endcase
      case ($urandom_range(0, 3))
         0: h = $urandom_range(0, 3);
         1: h = $urandom_range(20, 23);
         default: h = $urandom_range(0, 23);
      endcase
      return stamp(y, $urandom_range(1, 12), d, h, $urandom_range(0, 59),
                   $urandom_range(0, 60));
   endfunction

   task automatic send_item(input req_type t);
      req_data  <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_zone(input int hours, input bit east);
      csr_write <= 1'b1;
      csr_index <= CSR_ZONE_HOURS;
      csr_data  <= CsrDataWidth'(hours);
      @(posedge clock);
      csr_index <= CSR_ZONE_EAST;
      csr_data  <= {3'($urandom_range(0, 7)), east};
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int  left, burst, gap, gap_max, hours;
      bit  east;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero offset from reset
      send_item(stamp(4095, 15, 31, 31, 63, 63));
      send_item(stamp(0, 0, 0, 0, 0, 0));
      send_item(stamp(2024, 6, 15, 12, 30, 60));
      drain();

      set_zone(12, 1'b1);
      send_item(stamp(4095, 12, 31, 23, 59, 60));
      send_item(stamp(2000, 2, 28, 12, 0, 0));
      send_item(stamp(1900, 2, 28, 12, 1, 1));
      send_item(stamp(2024, 2, 29, 20, 2, 2));
      send_item(stamp(2023, 4, 30, 15, 3, 3));
      send_item(stamp(2023, 4, 31, 15, 4, 4));
      send_item(stamp(2023, 7, 0, 18, 5, 5));
      send_item(stamp(2023, 0, 31, 23, 6, 6));
      send_item(stamp(2023, 5, 10, 31, 7, 7));
      send_item(stamp(2023, 5, 10, 11, 8, 8));
      drain();

      set_zone(12, 1'b0);
      send_item(stamp(0, 1, 1, 0, 9, 9));
      send_item(stamp(2000, 3, 1, 5, 10, 10));
      send_item(stamp(1900, 3, 1, 5, 11, 11));
      send_item(stamp(2023, 3, 1, 5, 12, 12));
      send_item(stamp(2023, 5, 1, 11, 13, 13));
      send_item(stamp(2023, 8, 0, 3, 14, 14));
      send_item(stamp(2023, 13, 1, 0, 15, 15));
      send_item(stamp(2023, 6, 9, 12, 16, 16));
      send_item(stamp(2023, 6, 9, 31, 17, 17));
      drain();

      set_zone(15, 1'b0);
      send_item(stamp(2023, 1, 1, 0, 18, 18));
      send_item(stamp(4095, 12, 31, 23, 19, 19));
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin hours = 0;  east = 1'b0; end
            1: begin hours = 12; east = 1'b1; end
            2: begin hours = 12; east = 1'b0; end
            3: begin hours = 1;  east = 1'b0; end
            default: begin
               hours = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 15)
                                                   : $urandom_range(1, 12);
               east = $urandom_range(0, 1);
            end
         endcase
         set_zone(hours, east);
         if (p == 2 || p == 5) begin
            holds_asked <= holds_asked + 1;
         end
         gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
         left = 62;
         while (left > 0) begin
            burst = $urandom_range(1, 10);
            for (int k = 0; k < burst && left > 0; k++) begin
               send_item(random_stamp());
               left--;
            end
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         drain();
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
